// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file of this project.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define PE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is active.
`define PE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- design/pe_scan_pkg.sv -----
// Types and constants of the PE section name scanner.
// No dependencies; used by the parser, the top level and the checker.
package pe_scan_pkg;

    localparam int unsigned DOS_LAST_POS   = 63;
    localparam logic [31:0] DOS_SIZE       = 32'h0000_0040;
    localparam logic [31:0] OFFSET_MAX     = 32'h4000_0000;
    localparam int unsigned COFF_LAST_IDX  = 19;
    localparam int unsigned RECORD_LAST    = 39;
    localparam logic [3:0]  NAME_BYTES     = 4'd8;
    localparam logic [7:0]  CHAR_M         = 8'h4D;
    localparam logic [7:0]  CHAR_Z         = 8'h5A;

    localparam logic [63:0] TARGET_NAME_RESET   = 64'd431349129774;
    localparam logic [3:0]  TARGET_LENGTH_RESET = 4'd5;
    localparam logic [7:0]  SECTION_LIMIT_RESET = 8'd128;

    typedef enum logic [1:0] {
        CFG_TARGET_NAME   = 2'd0,
        CFG_TARGET_LENGTH = 2'd1,
        CFG_SECTION_LIMIT = 2'd2,
        CFG_UNUSED        = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        VERDICT_MATCH     = 2'd0,
        VERDICT_NO_MATCH  = 2'd1,
        VERDICT_BAD       = 2'd2,
        VERDICT_TRUNCATED = 2'd3
    } verdict_t;

    typedef enum logic [6:0] {
        PH_DOS  = 7'b000_0001,
        PH_GAP  = 7'b000_0010,
        PH_SIG  = 7'b000_0100,
        PH_COFF = 7'b000_1000,
        PH_OPT  = 7'b001_0000,
        PH_SECT = 7'b010_0000,
        PH_DONE = 7'b100_0000
    } phase_t;

    typedef struct packed {
        logic [63:0] target_name;
        logic [3:0]  target_length;
        logic [7:0]  section_limit;
    } scan_cfg_t;

    typedef struct packed {
        logic     valid;
        verdict_t verdict;
    } scan_result_t;

    // Expected bytes of the "PE\0\0" signature.
    function automatic logic [7:0] sig_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h50;
            2'd1:    b = 8'h45;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ----- design/pe_scan_parser.sv -----
// Byte-serial header parser: holds the per-image state and gives a verdict.
// Depends on pe_scan_pkg.
module pe_scan_parser (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic [7:0]               data_byte,
    input  logic                     last_byte,
    input  pe_scan_pkg::scan_cfg_t   cfg,
    output pe_scan_pkg::scan_result_t result
);
    import pe_scan_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [30:0] pos_reg, pos_next;
    logic [31:0] offset_reg, offset_next;
    logic [7:0]  count_high_reg, count_high_next;
    logic [7:0]  sections_total_reg, sections_total_next;
    logic [15:0] opt_reg, opt_next;
    logic [7:0]  seen_reg, seen_next;
    logic [5:0]  bir_reg, bir_next;
    logic        marks_reg, marks_next;

    logic [30:0] pos_inc;
    logic [7:0]  seen_inc;
    logic [15:0] opt_dec;
    logic [3:0]  name_len;
    logic [2:0]  name_idx;
    logic [7:0]  target_byte;
    logic        name_ok;

    assign pos_inc     = pos_reg + 31'd1;
    assign seen_inc    = seen_reg + 8'd1;
    assign opt_dec     = opt_reg - 16'd1;
    assign name_len    = (cfg.target_length > NAME_BYTES) ? NAME_BYTES : cfg.target_length;
    assign name_idx    = bir_reg[2:0];
    assign target_byte = cfg.target_name[{name_idx, 3'b000} +: 8];

    // A NUL in the target never matches; the byte right after a name shorter than eight bytes must be NUL.
    always_comb
    begin
        if ({1'b0, name_idx} < name_len)
        begin
            name_ok = (data_byte != 8'h00) && (data_byte == target_byte);
        end
        else if ({1'b0, name_idx} == name_len)
        begin
            name_ok = (data_byte == 8'h00);
        end
        else
        begin
            name_ok = 1'b1;
        end
    end

    always_comb
    begin
        phase_next          = phase_reg;
        pos_next            = pos_reg;
        offset_next         = offset_reg;
        count_high_next     = count_high_reg;
        sections_total_next = sections_total_reg;
        opt_next            = opt_reg;
        seen_next           = seen_reg;
        bir_next            = bir_reg;
        marks_next          = marks_reg;
        result.valid        = 1'b0;
        result.verdict      = VERDICT_TRUNCATED;

        if (step)
        begin
            case (phase_reg)
                PH_DOS:
                begin
                    if (pos_reg[5:0] == 6'd0 && data_byte != CHAR_M)
                    begin
                        marks_next = 1'b0;
                    end
                    if (pos_reg[5:0] == 6'd1 && data_byte != CHAR_Z)
                    begin
                        marks_next = 1'b0;
                    end
                    if (pos_reg[5:2] == 4'hF)
                    begin
                        offset_next[{pos_reg[1:0], 3'b000} +: 8] = data_byte;
                    end
                    pos_next = pos_inc;
                    if (pos_reg[5:0] == 6'(DOS_LAST_POS))
                    begin
                        if (!marks_next || offset_next < DOS_SIZE || offset_next > OFFSET_MAX)
                        begin
                            phase_next     = PH_DONE;
                            result.valid   = 1'b1;
                            result.verdict = VERDICT_BAD;
                        end
                        else
                        begin
                            phase_next = (offset_next == DOS_SIZE) ? PH_SIG : PH_GAP;
                            bir_next   = 6'd0;
                        end
                    end
                end
                PH_GAP:
                begin
                    pos_next = pos_inc;
                    if (pos_inc >= offset_reg[30:0])
                    begin
                        phase_next = PH_SIG;
                        bir_next   = 6'd0;
                    end
                end
                PH_SIG:
                begin
                    if (data_byte != sig_byte(bir_reg[1:0]))
                    begin
                        marks_next = 1'b0;
                    end
                    bir_next = bir_reg + 6'd1;
                    if (bir_reg == 6'd3)
                    begin
                        if (!marks_next)
                        begin
                            phase_next     = PH_DONE;
                            result.valid   = 1'b1;
                            result.verdict = VERDICT_BAD;
                        end
                        else
                        begin
                            phase_next = PH_COFF;
                            bir_next   = 6'd0;
                        end
                    end
                end
                PH_COFF:
                begin
                    case (bir_reg)
                        6'd2:    sections_total_next = data_byte;
                        6'd3:    count_high_next     = data_byte;
                        6'd16:   opt_next[7:0]       = data_byte;
                        6'd17:   opt_next[15:8]      = data_byte;
                        default: ;
                    endcase
                    bir_next = bir_reg + 6'd1;
                    if (bir_reg == 6'(COFF_LAST_IDX))
                    begin
                        // The section count is 16 bits; any high byte exceeds the 8-bit limit.
                        if (count_high_next != 8'd0 || sections_total_next == 8'd0
                            || sections_total_next > cfg.section_limit || opt_next == 16'd0)
                        begin
                            phase_next     = PH_DONE;
                            result.valid   = 1'b1;
                            result.verdict = VERDICT_BAD;
                        end
                        else
                        begin
                            phase_next = PH_OPT;
                            bir_next   = 6'd0;
                        end
                    end
                end
                PH_OPT:
                begin
                    opt_next = opt_dec;
                    if (opt_dec == 16'd0)
                    begin
                        phase_next = PH_SECT;
                        seen_next  = 8'd0;
                        bir_next   = 6'd0;
                        marks_next = 1'b1;
                    end
                end
                PH_SECT:
                begin
                    if (bir_reg[5:3] == 3'd0 && !name_ok)
                    begin
                        marks_next = 1'b0;
                    end
                    bir_next = bir_reg + 6'd1;
                    if (bir_reg == 6'(RECORD_LAST))
                    begin
                        seen_next = seen_inc;
                        if (marks_reg)
                        begin
                            phase_next     = PH_DONE;
                            result.valid   = 1'b1;
                            result.verdict = VERDICT_MATCH;
                        end
                        else if (seen_inc >= sections_total_reg)
                        begin
                            phase_next     = PH_DONE;
                            result.valid   = 1'b1;
                            result.verdict = VERDICT_NO_MATCH;
                        end
                        else
                        begin
                            bir_next   = 6'd0;
                            marks_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            if (last_byte)
            begin
                if (!result.valid && phase_reg != PH_DONE)
                begin
                    result.valid   = 1'b1;
                    result.verdict = VERDICT_TRUNCATED;
                end
                phase_next          = PH_DOS;
                pos_next            = 31'd0;
                offset_next         = 32'd0;
                count_high_next     = 8'd0;
                sections_total_next = 8'd0;
                opt_next            = 16'd0;
                seen_next           = 8'd0;
                bir_next            = 6'd0;
                marks_next          = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_DOS;
            pos_reg            <= 31'd0;
            offset_reg         <= 32'd0;
            count_high_reg     <= 8'd0;
            sections_total_reg <= 8'd0;
            opt_reg            <= 16'd0;
            seen_reg           <= 8'd0;
            bir_reg            <= 6'd0;
            marks_reg          <= 1'b1;
        end
        else
        begin
            phase_reg          <= phase_next;
            pos_reg            <= pos_next;
            offset_reg         <= offset_next;
            count_high_reg     <= count_high_next;
            sections_total_reg <= sections_total_next;
            opt_reg            <= opt_next;
            seen_reg           <= seen_next;
            bir_reg            <= bir_next;
            marks_reg          <= marks_next;
        end
    end

endmodule

// ----- design/pe_section_name_scanner.sv -----
// Top level of the PE section name scanner: stream ports, configuration
// registers, input stage and result register. Depends on pe_scan_pkg and pe_scan_parser.
//
// The block takes the bytes of one PE/COFF executable image in file order on
// the s_ stream, one byte per item, with s_tlast on the final byte, and gives
// at most one result item per image on the m_ stream. It checks the MZ mark of
// the 64-byte DOS header, skips forward to the header offset stored at 0x3C,
// checks the "PE\0\0" signature, reads the section count and optional-header
// size from the COFF header, skips the optional header, and compares each
// section name (cut at its first NUL) with the configured target name. The
// verdict is match, no match, bad header or truncated; it is sent as soon as
// it is decided, and bytes after it are dropped until the last byte, which
// readies the block for the next image. A header offset below 64 counts as a
// bad header. Throughput is one byte per clock cycle unless a result is held
// back on the m_ side: every byte is one step of the parser state machine, so
// the per-byte logic sets the rate. An accepted byte sits in the input register
// while the parser works on it, and a verdict that byte causes is registered
// in the result register before it shows on m_tvalid. An input register in
// front of the parser lets one more byte be accepted while a result waits on
// the m_ side. Configuration is written through the cfg_
// port, which is always ready; write it only while no image is in flight.
// Writes to an index beyond the register list are ignored.
module pe_section_name_scanner (
    input  logic        clk,
    input  logic        rst_n,
    // Byte stream in.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    // Verdict stream out.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] found, [2:1] verdict, [7:3] zero
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import pe_scan_pkg::*;

    scan_cfg_t    cfg_reg;
    scan_result_t step_result;

    logic         in_valid_reg, in_valid_next;
    logic [7:0]   in_byte_reg;
    logic         in_last_reg;
    logic         out_valid_reg, out_valid_next;
    verdict_t     out_verdict_reg;
    logic         advance;
    logic         s_accept;

    assign cfg_ready = 1'b1;

    // Configuration registers keep their value across images.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_name   <= TARGET_NAME_RESET;
            cfg_reg.target_length <= TARGET_LENGTH_RESET;
            cfg_reg.section_limit <= SECTION_LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_TARGET_NAME:   cfg_reg.target_name   <= cfg_data;
                CFG_TARGET_LENGTH: cfg_reg.target_length <= cfg_data[3:0];
                CFG_SECTION_LIMIT: cfg_reg.section_limit <= cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    // The held byte moves into the parser when the result register can take
    // whatever that byte produces.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        if (advance)
        begin
            out_valid_next = step_result.valid;
        end
        else
        begin
            out_valid_next = out_valid_reg && !m_tready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && step_result.valid)
        begin
            out_verdict_reg <= step_result.verdict;
        end
    end

    pe_scan_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .cfg       (cfg_reg),
        .result    (step_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_verdict_reg, (out_verdict_reg == VERDICT_MATCH)};

endmodule

// ----- design/pe_scan_checker.sv -----
// Port-level checker for the PE section name scanner, bound to the top level.
// Depends on pe_scan_pkg and assert_macros.svh.
module pe_scan_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [1:0]  cfg_index,
    input logic [63:0] cfg_data
);
    import pe_scan_pkg::*;
    `include "assert_macros.svh"

    // The found flag agrees with the verdict code.
    `PE_ASSERT_IMP(a_found_matches_verdict, clk, rst_n, m_tvalid, m_tdata[0] == (m_tdata[2:1] == VERDICT_MATCH))
    // Padding above the verdict stays zero.
    `PE_ASSERT_IMP(a_pad_zero, clk, rst_n, m_tvalid, m_tdata[7:3] == 5'd0)
    // With no result waiting, the input side never stalls.
    `PE_ASSERT_IMP(a_ready_when_out_empty, clk, rst_n, !m_tvalid, s_tready)
    // A stalled result holds.
    `PE_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind pe_section_name_scanner pe_scan_checker u_pe_scan_checker (.*);
